// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that post holds in the same cycle as pre.
`define ASSERT_SAME(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Checks that post holds in the cycle after pre.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== sv/bpfa_pkg.sv =====
// Types and constants shared by the page frame allocator modules.
package bpfa_pkg;

    localparam int WBITS = 8;
    localparam int WSH = 3;

    localparam int FUNC_W = 2;
    localparam int COUNT_W = 15;
    localparam int ADDR_W = 32;
    localparam int STATUS_W = 2;
    localparam int BASE_W = 26;

    localparam logic [FUNC_W-1:0] FUNC_ONE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_RRD,
        S_RWR
    } t_state;

    typedef struct packed {
        logic                init_step;
        logic                scan_load;
        logic                scan_one;
        logic                scan_step;
        logic                rng_load;
        logic                rng_free;
        logic                rng_read;
        logic                rng_write;
        logic                rng_skip;
        logic                reply;
        logic                reply_base;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic scan_done;
        logic scan_found;
        logic rng_out;
        logic rng_skip_last;
        logic rng_last;
        logic rng_alloc;
    } t_sts;

endpackage

// ===== sv/bpfa_ctrl.sv =====
// Controller state machine of the page frame allocator.
module bpfa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bpfa_pkg::FUNC_W-1:0]   i_func,
    input  logic [bpfa_pkg::COUNT_W-1:0]  i_count,
    input  bpfa_pkg::t_sts                i_sts,
    output bpfa_pkg::t_cmd                o_cmd,
    output logic                          o_busy
);
    import bpfa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   count_zero;

    assign count_zero = (i_count == '0);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands to the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (i_func)
                        FUNC_ONE: begin
                            o_cmd.scan_load = 1'b1;
                            o_cmd.scan_one = 1'b1;
                            n_state = S_SCAN;
                        end
                        FUNC_RUN: begin
                            if (count_zero) begin
                                o_cmd.reply = 1'b1;
                                o_cmd.status = ST_ZERO;
                            end else begin
                                o_cmd.scan_load = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_FREE: begin
                            if (count_zero) begin
                                o_cmd.reply = 1'b1;
                                o_cmd.status = ST_OK;
                            end else begin
                                o_cmd.rng_load = 1'b1;
                                o_cmd.rng_free = 1'b1;
                                n_state = S_RRD;
                            end
                        end
                        default: begin
                            o_cmd.reply = 1'b1;
                            o_cmd.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.scan_found) begin
                        o_cmd.rng_load = 1'b1;
                        n_state = S_RRD;
                    end else begin
                        o_cmd.reply = 1'b1;
                        o_cmd.status = ST_NOFIT;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RRD: begin
                if (i_sts.rng_out) begin
                    o_cmd.rng_skip = 1'b1;
                    if (i_sts.rng_skip_last) begin
                        o_cmd.reply = 1'b1;
                        o_cmd.reply_base = i_sts.rng_alloc;
                        o_cmd.status = ST_OK;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.rng_read = 1'b1;
                    n_state = S_RWR;
                end
            end
            S_RWR: begin
                o_cmd.rng_write = 1'b1;
                if (i_sts.rng_last) begin
                    o_cmd.reply = 1'b1;
                    o_cmd.reply_base = i_sts.rng_alloc;
                    o_cmd.status = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bpfa_dp.sv =====
// Datapath of the page frame allocator: bitmap memory, run scanner and range marker.
module bpfa_dp #(
    parameter int FRAMES = 16384,
    parameter int LOW_SEARCH_FRAMES = 1024,
    parameter int RESERVED_FRAMES = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpfa_pkg::t_cmd                i_cmd,
    input  logic [bpfa_pkg::COUNT_W-1:0]  i_count,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_address,
    output bpfa_pkg::t_sts                o_sts,
    output logic                          o_done,
    output logic [bpfa_pkg::STATUS_W-1:0] o_status,
    output logic [bpfa_pkg::BASE_W-1:0]   o_base_address
);
    import bpfa_pkg::*;

    localparam int FB = $clog2(FRAMES);
    localparam int LW = FB + 1;
    localparam int PBW = $clog2(PAGE_BYTES);
    localparam int IB = ADDR_W - PBW;
    localparam int CW = ((IB > FB) ? IB : FB) + 1;
    localparam int NW = (FRAMES + WBITS - 1) / WBITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int LOWL = (LOW_SEARCH_FRAMES < FRAMES) ? LOW_SEARCH_FRAMES : FRAMES;
    localparam logic [CW-1:0] SPAN = CW'(64'(1) << IB);

    // Bitmap storage, one bit per frame.
    logic [WBITS-1:0] r_mem [NW];
    logic [WBITS-1:0] r_rdata;

    // Reset fill pass.
    logic [AW-1:0]    r_iaddr;
    logic [WBITS-1:0] init_word;

    // Scanner state.
    logic [AW:0]         r_raddr;
    logic                r_rv;
    logic [AW-1:0]       r_rdaddr;
    logic [LW-1:0]       r_limit;
    logic [COUNT_W-1:0]  r_cnt;
    logic [COUNT_W-1:0]  r_run;
    logic [CW-1:0]       r_start;
    logic                r_found;
    logic [LW:0]         lim_up;
    logic [AW:0]         nw_lim;
    logic                issue;
    logic                scan_last;
    logic [COUNT_W-1:0]  v_run;
    logic [CW-1:0]       v_start;
    logic                v_found;

    // Range marker state.
    logic [CW-1:0]      r_f;
    logic [COUNT_W-1:0] r_rem;
    logic               r_rfree;
    logic [WSH-1:0]     lo;
    logic [WSH:0]       room;
    logic [WSH:0]       k;
    logic [WBITS-1:0]   mask;
    logic [CW-1:0]      gap;
    logic [CW-1:0]      nf;

    // Result register.
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [BASE_W-1:0]   r_base;

    // Initial word contents: reserved frames set.
    always_comb begin
        for (int j = 0; j < WBITS; j++) begin
            init_word[j] = ((32'(r_iaddr) << WSH) + 32'(j)) < 32'(RESERVED_FRAMES);
        end
    end

    // Scan bounds and read issue.
    assign lim_up = {1'b0, r_limit} + (LW + 1)'(WBITS - 1);
    assign nw_lim = (AW + 1)'(lim_up >> WSH);
    assign issue = i_cmd.scan_step && (r_raddr < nw_lim);
    assign scan_last = (r_rdaddr == AW'(nw_lim - 1'b1));

    // Run tracking across the bits of the word just read.
    always_comb begin
        logic [CW-1:0] v_idx;
        logic          v_free;
        v_run = r_run;
        v_start = r_start;
        v_found = r_found;
        for (int j = 0; j < WBITS; j++) begin
            v_idx = (CW'(r_rdaddr) << WSH) | CW'(j);
            v_free = !r_rdata[j] && (v_idx < CW'(r_limit));
            if (!v_found) begin
                if (v_free) begin
                    if (v_run == '0) begin
                        v_start = v_idx;
                    end
                    v_run = v_run + 1'b1;
                    if (v_run == r_cnt) begin
                        v_found = 1'b1;
                    end
                end else begin
                    v_run = '0;
                end
            end
        end
    end

    // Range word mask and skip distance.
    assign lo = r_f[WSH-1:0];
    assign room = (WSH + 1)'(WBITS) - {1'b0, lo};
    assign k = (r_rem < COUNT_W'(room)) ? r_rem[WSH:0] : room;
    assign gap = SPAN - r_f;

    always_comb begin
        for (int j = 0; j < WBITS; j++) begin
            mask[j] = ((WSH + 1)'(j) >= {1'b0, lo}) && ((WSH + 1)'(j) < ({1'b0, lo} + k));
        end
        nf = r_f + CW'(k);
        if (r_rfree && nf == SPAN) begin
            nf = '0;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.init_last = (r_iaddr == AW'(NW - 1));
        o_sts.scan_done = r_rv && (v_found || scan_last);
        o_sts.scan_found = v_found;
        o_sts.rng_out = (r_f >= CW'(FRAMES));
        o_sts.rng_skip_last = (CW'(r_rem) <= gap);
        o_sts.rng_last = (r_rem == COUNT_W'(k));
        o_sts.rng_alloc = !r_rfree;
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_step) begin
            r_mem[r_iaddr] <= init_word;
        end else if (i_cmd.rng_write) begin
            r_mem[r_f[AW+WSH-1:WSH]] <= r_rfree ? (r_rdata & ~mask) : (r_rdata | mask);
        end
        if (issue) begin
            r_rdata <= r_mem[r_raddr[AW-1:0]];
        end else if (i_cmd.rng_read) begin
            r_rdata <= r_mem[r_f[AW+WSH-1:WSH]];
        end
    end

    // Fill pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iaddr <= '0;
        end else if (i_cmd.init_step) begin
            r_iaddr <= r_iaddr + 1'b1;
        end
    end

    // Scanner registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (i_cmd.scan_load) begin
            r_raddr <= '0;
            r_rv <= 1'b0;
            r_run <= '0;
            r_found <= 1'b0;
            r_limit <= i_cmd.scan_one ? LW'(LOWL) : LW'(FRAMES);
            r_cnt <= i_cmd.scan_one ? COUNT_W'(1) : i_count;
        end else if (i_cmd.scan_step) begin
            if (issue) begin
                r_raddr <= r_raddr + 1'b1;
                r_rdaddr <= r_raddr[AW-1:0];
            end
            r_rv <= issue;
            if (r_rv) begin
                r_run <= v_run;
                r_start <= v_start;
                r_found <= v_found;
            end
        end
    end

    // Range marker registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rng_load) begin
            r_rfree <= i_cmd.rng_free;
            if (i_cmd.rng_free) begin
                r_f <= CW'(i_address >> PBW);
                r_rem <= i_count;
            end else begin
                r_f <= v_start;
                r_rem <= r_cnt;
            end
        end else if (i_cmd.rng_write) begin
            r_f <= nf;
            r_rem <= r_rem - COUNT_W'(k);
        end else if (i_cmd.rng_skip) begin
            r_f <= '0;
            r_rem <= r_rem - gap[COUNT_W-1:0];
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.reply;
        end
        if (i_cmd.reply) begin
            r_status <= i_cmd.status;
            r_base <= i_cmd.reply_base ? BASE_W'(64'(r_start) << PBW) : '0;
        end
    end

    assign o_done = r_done;
    assign o_status = r_status;
    assign o_base_address = r_base;

endmodule

// ===== sv/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page frame allocator.
// A request word (i_func, i_count, i_address) is taken at a rising edge with
// start high and busy low. Each request gives exactly one result word on
// o_status and o_base_address, shown for one cycle while o_done is high.
// Function 0 takes the lowest free frame among the low search window,
// function 1 takes the lowest first-fit run of i_count frames, function 2
// clears i_count frames from a byte address, and function 3 does nothing.
// Zero-count and unused requests answer in the cycle after acceptance.
// An allocation scans the bitmap eight frames per cycle through one memory
// read port, then marks the run by reading and writing each bitmap byte
// touched. A free reads and writes each bitmap byte inside the map and
// skips over each out-of-range stretch.
// Work is one request at a time; busy stays high until the result is issued.
// After reset the block runs a fill pass, with busy high, that writes the
// bitmap and marks the reserved frames used.
// The receiver cannot stall: each result word is taken in its strobe cycle.
module bitmap_page_frame_allocator #(
    parameter int FRAMES = 16384,
    parameter int LOW_SEARCH_FRAMES = 1024,
    parameter int RESERVED_FRAMES = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bpfa_pkg::FUNC_W-1:0]   i_func,
    input  logic [bpfa_pkg::COUNT_W-1:0]  i_count,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_address,
    output logic                          o_done,
    output logic [bpfa_pkg::STATUS_W-1:0] o_status,
    output logic [bpfa_pkg::BASE_W-1:0]   o_base_address
);
    import bpfa_pkg::*;

    `include "assert_macros.svh"

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    bpfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_count (i_count),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Bitmap and search datapath.
    bpfa_dp #(
        .FRAMES            (FRAMES),
        .LOW_SEARCH_FRAMES (LOW_SEARCH_FRAMES),
        .RESERVED_FRAMES   (RESERVED_FRAMES),
        .PAGE_BYTES        (PAGE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_count        (i_count),
        .i_address      (i_address),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_base_address (o_base_address)
    );

    // A failed request never reports a base address.
    `ASSERT_SAME(a_fail_base_zero, i_clk, i_rst_n, o_done && (o_status != ST_OK), o_base_address == '0)
    // An accepted request either keeps the block busy or answers next cycle.
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done)
    // A zero-count status only follows a run request.
    `ASSERT_SAME(a_zero_from_run, i_clk, i_rst_n, o_done && (o_status == ST_ZERO), $past(i_func) == FUNC_RUN)

endmodule

// ===== tb/sv/bitmap_page_frame_allocator_test.sv =====
// Testbench for the bitmap page frame allocator: directed and random requests checked against a bitmap predictor.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_test;
    import bpfa_pkg::*;

    localparam int N_FRAMES = 16384;
    localparam int WINDOW = 1024;
    localparam int RESERVED = 1024;
    localparam int PAGE = 4096;
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  address;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BASE_W-1:0]   base;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [FUNC_W-1:0] i_func = '0;
    logic [COUNT_W-1:0] i_count = '0;
    logic [ADDR_W-1:0] i_address = '0;
    logic o_done;
    logic [STATUS_W-1:0] o_status;
    logic [BASE_W-1:0] o_base_address;

    t_request request_queue[$];
    t_answer answer_queue[$];
    bit frame_used[N_FRAMES];
    int fail_count = 0;
    int idle_left = 0;
    bit idle_enabled = 1'b1;
    // Busy as seen at the last rising edge, so acceptance is judged race free.
    logic busy_at_edge = 1'b1;

    bitmap_page_frame_allocator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_count(i_count), .i_address(i_address),
        .o_done(o_done), .o_status(o_status), .o_base_address(o_base_address)
    );

    always #4 i_clk = ~i_clk;

    // Reports one mismatch and counts it.
    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Computes the answer for one request and updates the predicted bitmap.
    function automatic t_answer allocate_predict(input t_request r);
        t_answer a;
        int run_start;
        int run_len;
        longint addr;
        longint idx;
        a.status = ST_OK;
        a.base = '0;
        run_start = 0;
        run_len = 0;
        if (r.func == FUNC_ONE) begin
            a.status = ST_NOFIT;
            for (int i = 0; i < WINDOW; i++) begin
                if (!frame_used[i]) begin
                    frame_used[i] = 1'b1;
                    a.status = ST_OK;
                    a.base = BASE_W'(longint'(i) * PAGE);
                    break;
                end
            end
        end else if (r.func == FUNC_RUN) begin
            if (r.count == 0) begin
                a.status = ST_ZERO;
            end else begin
                for (int i = 0; i < N_FRAMES && run_len < r.count; i++) begin
                    if (!frame_used[i]) begin
                        if (run_len == 0) run_start = i;
                        run_len++;
                    end else begin
                        run_len = 0;
                    end
                end
                if (run_len < r.count) begin
                    a.status = ST_NOFIT;
                end else begin
                    for (int i = 0; i < r.count; i++) frame_used[run_start + i] = 1'b1;
                    a.base = BASE_W'(longint'(run_start) * PAGE);
                end
            end
        end else if (r.func == FUNC_FREE) begin
            for (int i = 0; i < r.count; i++) begin
                addr = (longint'(r.address) + longint'(i) * PAGE) & 64'hFFFF_FFFF;
                idx = addr / PAGE;
                if (idx < N_FRAMES) frame_used[idx] = 1'b0;
            end
        end
        return a;
    endfunction

    function automatic t_request make_request(input logic [FUNC_W-1:0] f, input int c,
                                              input logic [ADDR_W-1:0] a);
        t_request r;
        r.func = f;
        r.count = COUNT_W'(c);
        r.address = a;
        return r;
    endfunction

    task automatic drive_next();
        t_request r;
        r = request_queue.pop_front();
        start <= 1'b1;
        i_func <= r.func;
        i_count <= r.count;
        i_address <= r.address;
    endtask

    // Driver: presents queued request words at the falling edge, with idle bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy_at_edge) begin
            // Previous word was accepted at the last rising edge.
            if (idle_enabled && idle_left == 0 && $urandom_range(0, 3) == 0)
                idle_left = $urandom_range(1, 13);
            if (idle_left == 0 && request_queue.size() > 0) begin
                drive_next();
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (idle_left > 0) begin
                idle_left--;
            end else if (request_queue.size() > 0) begin
                drive_next();
            end
        end
    end

    // Acceptance tracking and prediction at the rising edge.
    always @(posedge i_clk) begin
        busy_at_edge <= busy;
        if (i_rst_n && start && !busy) begin
            answer_queue.push_back(allocate_predict({i_func, i_count, i_address}));
        end
    end

    // Monitor: compares each result word with the oldest expected answer.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (answer_queue.size() == 0) begin
                report("unexpected result word", o_status, -1);
            end else begin
                want = answer_queue.pop_front();
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_base_address !== want.base)
                    report("base_address", o_base_address, want.base);
            end
        end
    end

    // Stimulus: directed corners, then mostly alloc/free traffic with small runs.
    initial begin
        t_request r;
        int pick;
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < N_FRAMES; i++) frame_used[i] = (i < RESERVED);
        request_queue.push_back(make_request(FUNC_ONE, 0, '0));
        request_queue.push_back(make_request(FUNC_ONE, 32767, '1));
        request_queue.push_back(make_request(FUNC_RUN, 0, '0));
        request_queue.push_back(make_request(FUNC_RUN, 1, '0));
        request_queue.push_back(make_request(FUNC_RUN, 16384, '0));
        request_queue.push_back(make_request(FUNC_RUN, 32767, '0));
        request_queue.push_back(make_request(FUNC_RUN, 15360, '0));
        request_queue.push_back(make_request(FUNC_RUN, 1, '0));
        request_queue.push_back(make_request(FUNC_FREE, 0, 32'h0040_0000));
        request_queue.push_back(make_request(FUNC_FREE, 16384, 32'h0040_0123));
        request_queue.push_back(make_request(FUNC_FREE, 5, 32'hFFFF_E000));
        request_queue.push_back(make_request(FUNC_FREE, 3, 32'h03FF_F000));
        request_queue.push_back(make_request(FUNC_FREE, 2, 32'h0400_0000));
        request_queue.push_back(make_request(FUNC_NOP, 32767, '1));
        request_queue.push_back(make_request(FUNC_FREE, 1000, 32'h0000_0FFF));
        request_queue.push_back(make_request(FUNC_ONE, 0, '0));
        // Take a 1023-frame run, then two single frames from the low window.
        request_queue.push_back(make_request(FUNC_RUN, 1023, '0));
        request_queue.push_back(make_request(FUNC_ONE, 0, '0));
        request_queue.push_back(make_request(FUNC_ONE, 0, '0));
        request_queue.push_back(make_request(FUNC_FREE, 32767, 32'h0000_0000));
        request_queue.push_back(make_request(FUNC_RUN, 16384, '0));
        request_queue.push_back(make_request(FUNC_FREE, 16384, 32'h0000_0000));
        for (int n = 0; n < 650; n++) begin
            pick = $urandom_range(0, 99);
            addr = $urandom_range(0, 16383) * PAGE + ($urandom_range(0, 7) == 0 ? $urandom : 0);
            if ($urandom_range(0, 15) == 0) addr = $urandom;
            if (pick < 30) r = make_request(FUNC_ONE, $urandom_range(0, 32767), $urandom);
            else if (pick < 60) r = make_request(FUNC_RUN, $urandom_range(0, 64), $urandom);
            else if (pick < 63) r = make_request(FUNC_RUN, $urandom_range(0, 32767), $urandom);
            else if (pick < 93) r = make_request(FUNC_FREE, $urandom_range(0, 128), addr);
            else if (pick < 97)
                r = make_request(FUNC_FREE, $urandom_range(0, 32767), $urandom);
            else r = make_request(FUNC_NOP, $urandom_range(0, 32767), $urandom);
            request_queue.push_back(r);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (request_queue.size() < 60);
        idle_enabled = 1'b0;
        wait (request_queue.size() == 0);
        @(posedge i_clk);
        while (start || answer_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && answer_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: reports failure and stops if the test has not finished.
    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/bpfa_pkg.sv
sv/bpfa_ctrl.sv
sv/bpfa_dp.sv
sv/bitmap_page_frame_allocator.sv
tb/sv/bitmap_page_frame_allocator_test.sv
